// ===== src/lamp_out_current_monitor_unit_macros.svh =====
// Assertion macros for the lamp-out monitor checker file (lmon_chk).
`ifndef LAMP_OUT_CURRENT_MONITOR_UNIT_MACROS_SVH
`define LAMP_OUT_CURRENT_MONITOR_UNIT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define LMON_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lamp monitor check failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define LMON_ASSERT_NEXT(lbl, ante, cons) \
  `LMON_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== src/lmon_pkg.sv =====
// Types and constants of the lamp-out current monitor.
package lmon_pkg;

  localparam int GrpIdxW    = 3;
  localparam int MaskW      = 3;
  localparam int CurW       = 16;
  localparam int PctW       = 7;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 1;
  localparam int LampCombos = 2 ** MaskW;
  localparam int MaxGroups  = 2 ** GrpIdxW;
  localparam int SlotW      = GrpIdxW + MaskW;

  // product of baseline and percent, wide enough for current * 100 + 100 too
  localparam int ProdW = CurW + PctW;
  localparam int PercentFull = 100;

  // input word: group_index, lamp_mask, current_ma from bit 0 up
  localparam int InFieldW = GrpIdxW + MaskW + CurW;
  localparam int InW      = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW = 3;
  localparam int OutW      = 8;

  localparam logic [PctW-1:0] PctReset  = PctW'(70);
  localparam logic [CurW-1:0] LminReset = CurW'(50);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAULT_PERCENT = 1'b0,
    CFG_LEARN_MIN     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic group_fault;
    logic baseline_learned;
    logic new_fault;
  } dec_t;

endpackage

// ===== src/lmon_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lmon_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lmon_eval.sv =====
// Learn-or-check decision for one lamp group word.
module lmon_eval import lmon_pkg::*; (
  input  logic            grp_ok_i,
  input  logic [MaskW-1:0] mask_i,
  input  logic [CurW-1:0] cur_i,
  input  logic [CurW-1:0] base_i,
  input  logic            base_valid_i,
  input  logic            fault_i,
  input  logic [PctW-1:0] pct_i,
  input  logic [CurW-1:0] lmin_i,
  output dec_t            dec_o
);

  logic [CurW-1:0]  base_eff;
  logic [ProdW-1:0] thresh_x100;
  logic [ProdW-1:0] cur_x100;
  logic             below;

  assign base_eff    = base_valid_i ? base_i : '0;
  assign thresh_x100 = ProdW'(base_eff) * ProdW'(pct_i);
  // cur < floor(t / 100) holds exactly when cur * 100 + 100 <= t
  assign cur_x100    = ProdW'(cur_i) * ProdW'(PercentFull) + ProdW'(PercentFull);
  assign below       = (cur_x100 <= thresh_x100);

  always_comb begin
    dec_o = '0;
    if (grp_ok_i) begin
      dec_o.group_fault = fault_i;
      if (mask_i != '0) begin
        if (base_eff == '0) begin
          dec_o.baseline_learned = (cur_i >= lmin_i);
        end else if (below && !fault_i) begin
          dec_o.new_fault   = 1'b1;
          dec_o.group_fault = 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/lamp_out_current_monitor_unit.sv =====
// Top level of the lamp-out current monitor.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    one lamp group word
//   m_axis    out        m_axis_tvalid/m_axis_tready    one result word
//   cfg       in         cfg_we_i                       threshold registers
//
// One word per cycle sustained while the output is taken; each word passes
// the baseline RAM read, then the decision into the output register.
// Back-to-back hits on the same slot are served by a one-entry write bypass.
// Reset clears the baseline valid bits and the fault latches at once, so
// words are accepted right after reset. A stalled output holds the decision
// stage, which in turn drops s_axis_tready.
module lamp_out_current_monitor_unit import lmon_pkg::*; #(
  parameter int GROUP_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InW-1:0]      s_axis_tdata,   // group_index, lamp_mask, current_ma, pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata,   // new_fault, baseline_learned, group_fault, pad
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // only groups the 3-bit index can reach get storage
  localparam int GrpUsed = (GROUP_COUNT < MaxGroups) ? GROUP_COUNT : MaxGroups;
  localparam int Depth   = GrpUsed * LampCombos;
  localparam int AW      = $clog2(Depth);
  localparam int GW      = (GrpUsed > 1) ? $clog2(GrpUsed) : 1;

  logic [PctW-1:0] pct_q;
  logic [CurW-1:0] lmin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q  <= PctReset;
      lmin_q <= LminReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FAULT_PERCENT: pct_q  <= cfg_data_i[PctW-1:0];
        CFG_LEARN_MIN:     lmin_q <= cfg_data_i[CurW-1:0];
        default:           ;
      endcase
    end
  end

  // input unpack
  logic [GrpIdxW-1:0] in_grp;
  logic [MaskW-1:0]   in_mask;
  logic [CurW-1:0]    in_cur;
  logic [SlotW-1:0]   in_slot;
  logic               accept;

  assign in_grp  = s_axis_tdata[GrpIdxW-1:0];
  assign in_mask = s_axis_tdata[GrpIdxW +: MaskW];
  assign in_cur  = s_axis_tdata[GrpIdxW+MaskW +: CurW];
  assign in_slot = {in_grp, in_mask};
  assign accept  = s_axis_tvalid && s_axis_tready;

  // decision stage
  logic               s1_v_q;
  logic [GrpIdxW-1:0] s1_grp_q;
  logic [MaskW-1:0]   s1_mask_q;
  logic [CurW-1:0]    s1_cur_q;
  logic               fwd_v_q;
  logic [CurW-1:0]    fwd_data_q;
  logic               s1_adv;
  logic               s1_grp_ok;
  logic [SlotW-1:0]   s1_slot;
  logic [CurW-1:0]    ram_rdata;
  logic [CurW-1:0]    s1_base;
  logic               s1_base_valid;
  logic               s1_fault;
  logic               wr_en;
  dec_t               dec;

  logic [Depth-1:0]   valid_q;
  logic [GrpUsed-1:0] fault_q;

  logic               out_v_q;
  dec_t               out_q;

  assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign s1_grp_ok     = (32'(s1_grp_q) < 32'(GROUP_COUNT));
  assign s1_slot       = {s1_grp_q, s1_mask_q};
  assign s1_base       = fwd_v_q ? fwd_data_q : ram_rdata;
  assign s1_base_valid = s1_grp_ok && valid_q[s1_slot[AW-1:0]];
  assign s1_fault      = s1_grp_ok && fault_q[s1_grp_q[GW-1:0]];
  assign wr_en         = s1_adv && dec.baseline_learned;

  lmon_ram #(
    .Width(CurW),
    .Depth(Depth)
  ) u_base_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_slot[AW-1:0]),
    .wdata_i(s1_cur_q),
    .re_i   (accept),
    .raddr_i(in_slot[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  lmon_eval u_eval (
    .grp_ok_i    (s1_grp_ok),
    .mask_i      (s1_mask_q),
    .cur_i       (s1_cur_q),
    .base_i      (s1_base),
    .base_valid_i(s1_base_valid),
    .fault_i     (s1_fault),
    .pct_i       (pct_q),
    .lmin_i      (lmin_q),
    .dec_o       (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_grp_q   <= in_grp;
      s1_mask_q  <= in_mask;
      s1_cur_q   <= in_cur;
      // RAM returns old data when the slot is written in the same cycle
      fwd_v_q    <= wr_en && (s1_slot == in_slot);
      fwd_data_q <= s1_cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
    end else begin
      if (wr_en) begin
        valid_q[s1_slot[AW-1:0]] <= 1'b1;
      end
      if (s1_adv && dec.new_fault) begin
        fault_q[s1_grp_q[GW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= dec;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(OutW - OutFieldW)'(0), out_q};

endmodule

// ===== src/lmon_chk.sv =====
// Port-level checker for the lamp-out monitor, bound to the top level.
`include "lamp_out_current_monitor_unit_macros.svh"

module lmon_chk import lmon_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  // a stalled result word holds
  `LMON_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a new fault is always reported as latched
  `LMON_ASSERT(a_fault_latched, !(m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[2]))

  // one word never both learns and faults
  `LMON_ASSERT(a_learn_xor_fault, !(m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1]))

  // input backpressure only comes from a stalled output
  `LMON_ASSERT(a_ready_cause, s_axis_tready || (m_axis_tvalid && !m_axis_tready))

endmodule

bind lamp_out_current_monitor_unit lmon_chk u_lmon_chk (.*);

// ===== dv/tb_lamp_out_current_monitor_unit.sv =====
// Self-checking testbench for the lamp-out current monitor: directed and random group words.

class lamp_fault_tracker;
  int unsigned    group_count;
  int unsigned    fault_pct;
  int unsigned    learn_min;
  logic [15:0]    baseline [lmon_pkg::MaxGroups * lmon_pkg::LampCombos];
  bit             latched [lmon_pkg::MaxGroups];
  lmon_pkg::dec_t due_status [$];
  int unsigned    n_words;
  int unsigned    n_dark;
  int unsigned    n_learned;
  int unsigned    n_faults;
  int unsigned    n_errors;

  function new(int unsigned groups);
    group_count = groups;
    fault_pct = lmon_pkg::PctReset;
    learn_min = lmon_pkg::LminReset;
    foreach (baseline[i]) baseline[i] = '0;
    foreach (latched[i]) latched[i] = 1'b0;
    n_words = 0;
    n_dark = 0;
    n_learned = 0;
    n_faults = 0;
    n_errors = 0;
  endfunction

  function void set_register(lmon_pkg::cfg_idx_e idx, logic [15:0] data);
    case (idx)
      lmon_pkg::CFG_FAULT_PERCENT: fault_pct = data[lmon_pkg::PctW-1:0];
      lmon_pkg::CFG_LEARN_MIN:     learn_min = data;
      default: ;
    endcase
  endfunction

  function int unsigned threshold(int unsigned slot);
    return (baseline[slot] * fault_pct) / lmon_pkg::PercentFull;
  endfunction

  // Predict the status word of one accepted group word and queue it.
  function void take_group_word(int unsigned grp, int unsigned mask, int unsigned cur);
    lmon_pkg::dec_t st;
    int unsigned    slot;
    st = '0;
    n_words++;
    if (grp < group_count) begin
      if (mask != 0) begin
        slot = grp * lmon_pkg::LampCombos + mask;
        if (baseline[slot] == 0) begin
          if (cur >= learn_min) begin
            baseline[slot] = cur[15:0];
            st.baseline_learned = 1'b1;
            n_learned++;
          end
        end else if (cur < threshold(slot) && !latched[grp]) begin
          latched[grp] = 1'b1;
          st.new_fault = 1'b1;
          n_faults++;
        end
      end else begin
        n_dark++;
      end
      st.group_fault = latched[grp];
    end
    due_status.push_back(st);
  endfunction

  function void check_status(lmon_pkg::dec_t got);
    lmon_pkg::dec_t want;
    if (due_status.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("unexpected result word: %b", got);
      return;
    end
    want = due_status.pop_front();
    if (got.new_fault !== want.new_fault || got.baseline_learned !== want.baseline_learned ||
        got.group_fault !== want.group_fault) begin
      n_errors++;
      if (n_errors <= 10)
        $display("wrong result word: new_fault %b/%b learned %b/%b group_fault %b/%b (exp/act)",
                 want.new_fault, got.new_fault, want.baseline_learned, got.baseline_learned,
                 want.group_fault, got.group_fault);
    end
  endfunction
endclass

module tb_lamp_out_current_monitor_unit;
  import lmon_pkg::*;

  localparam int NumGroups  = 8;
  localparam int NumPhases  = 8;
  localparam int PhaseWords = 238;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bit                  send_idle_on = 1'b0;
  bit                  take_idle_on = 1'b0;
  int unsigned         take_stall = 0;
  lamp_fault_tracker   lamp_book;

  int unsigned phase_pct [NumPhases]  = '{0, 0, 1, 50, 100, 127, 70, 99};
  int unsigned phase_lmin [NumPhases] = '{65535, 0, 1000, 50, 65535, 200, 50, 30000};

  lamp_out_current_monitor_unit #(
    .GROUP_COUNT(NumGroups)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each accepted word, then, while take_idle_on is set, stall for a random number of cycles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        lamp_book.check_status(dec_t'(m_axis_tdata[OutFieldW-1:0]));
        take_stall = take_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (take_stall > 0) begin
        take_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Call at a rising edge; returns at the edge that takes the word, valid still high.
  task automatic send_group_word(int unsigned grp, int unsigned mask, int unsigned cur);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cur[CurW-1:0], mask[MaskW-1:0], grp[GrpIdxW-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lamp_book.take_group_word(grp, mask, cur);
  endtask

  // Hold the sender until every pending result word is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (lamp_book.due_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    lamp_book.set_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly random currents, some pinned to zero, full scale, or next to a decision edge.
  function automatic int unsigned pick_current(int unsigned grp, int unsigned mask);
    int unsigned slot;
    int unsigned edge_ma;
    int unsigned v;
    slot = grp * LampCombos + mask;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2, 3, 4: begin
        edge_ma = (lamp_book.baseline[slot] != 0) ? lamp_book.threshold(slot)
                                                  : lamp_book.learn_min;
        v = edge_ma + $urandom_range(0, 4);
        v = (v < 2) ? 0 : v - 2;
        return (v > 65535) ? 65535 : v;
      end
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    int unsigned grp;
    int unsigned mask;
    int unsigned pct;
    int unsigned lmin;
    lamp_book = new(NumGroups);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under reset settings, back to back.
    send_group_word(0, 0, 65535);  // all lamps dark
    send_group_word(0, 1, 49);     // just under learn minimum
    send_group_word(0, 1, 50);     // learn at minimum
    send_group_word(0, 1, 35);     // exactly at threshold: no fault
    send_group_word(0, 1, 34);     // first latch
    send_group_word(0, 1, 0);      // already latched
    send_group_word(0, 0, 0);      // dark word shows latch
    send_group_word(7, 7, 65535);
    send_group_word(7, 7, 65535);
    send_group_word(1, 2, 0);
    send_group_word(3, 5, 50);
    send_group_word(3, 6, 65535);
    drain_results();

    // Percent above full scale with junk in the unused data bits, learn minimum zero.
    write_register(CFG_FAULT_PERCENT, {9'($urandom), 7'd127});
    write_register(CFG_LEARN_MIN, 16'd0);
    send_group_word(2, 4, 0);      // zero stored, slot stays unlearned
    send_group_word(2, 4, 0);
    send_group_word(2, 4, 65535);
    send_group_word(2, 4, 65535);  // threshold beyond any current
    send_group_word(3, 5, 63);
    send_group_word(3, 5, 64);
    send_group_word(4, 1, 1);
    send_group_word(4, 1, 0);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      pct  = phase_pct[p];
      lmin = phase_lmin[p];
      if (p == NumPhases - 1) begin
        pct  = $urandom_range(0, 127);
        lmin = $urandom_range(0, 2000);
      end
      write_register(CFG_FAULT_PERCENT, {9'($urandom), pct[PctW-1:0]});
      write_register(CFG_LEARN_MIN, lmin[CurW-1:0]);
      for (int n = 0; n < PhaseWords; n++) begin
        if (n % 50 == 0) begin
          send_idle_on = ($urandom_range(0, 3) != 0);
          take_idle_on = ($urandom_range(0, 3) != 0);
        end
        grp  = $urandom_range(0, MaxGroups - 1);
        mask = $urandom_range(0, LampCombos - 1);
        send_group_word(grp, mask, pick_current(grp, mask));
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    $display("sent %0d group words (%0d dark) over %0d register settings",
             lamp_book.n_words, lamp_book.n_dark, NumPhases + 2);
    $display("%0d baselines learned, %0d faults latched, %0d bad result words",
             lamp_book.n_learned, lamp_book.n_faults, lamp_book.n_errors);
    if (lamp_book.n_errors == 0 && lamp_book.due_status.size() == 0) begin
      $display("lamp_out_current_monitor_unit: match");
    end else begin
      $display("lamp_out_current_monitor_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout waiting for result words");
    $display("lamp_out_current_monitor_unit: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lmon_pkg.sv
src/lmon_ram.sv
src/lmon_eval.sv
src/lamp_out_current_monitor_unit.sv
src/lmon_chk.sv
dv/tb_lamp_out_current_monitor_unit.sv
